[rtl/sca_pkg.sv]
package sca_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int SC_W        = 3;
    localparam int CLASS_W     = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CLASSES = 4;

    // defaults for top level parameters
    localparam int POOL_CHUNKS_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    // smallest chunk is 128 bytes
    localparam int CHUNK_SHIFT0 = 7;

    // transaction kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CLASS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CLASS1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CLASS2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CLASS3 = 3'd3;

    // pool base reset values
    localparam logic [ADDR_W-1:0] BASE_RESET0 = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] BASE_RESET1 = 32'h0001_0000;
    localparam logic [ADDR_W-1:0] BASE_RESET2 = 32'h0002_0000;
    localparam logic [ADDR_W-1:0] BASE_RESET3 = 32'h0003_0000;

    // classified command handed from front to back
    typedef struct packed {
        logic                   kind;
        logic [SC_W-1:0]        size_class;
        logic [ADDR_W-1:0]      addr;
        logic                   class_ok;
        logic [NUM_CLASSES-1:0] cand;
    } t_cmd;

    // log2 of the chunk size of a class
    function automatic logic [3:0] chunk_shift(input logic [CLASS_W-1:0] c);
        return 4'(CHUNK_SHIFT0) + 4'(c);
    endfunction

endpackage

[rtl/size_class_chunk_allocator_top.sv]
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+----------------------------
// command   | i_kind, i_size_class, i_chunk_address          | start && !busy
// result    | o_status, o_result_address, o_result_class     | o_result_strobe, one cycle
// config    | i_cfg_index, i_cfg_data                        | i_cfg_valid && o_cfg_ready
//
// in the back end each transaction has a read phase, which reads the per-class link and
// in-use ram, and a resolve phase, which updates the free list head and writes the ram back.
// from an idle block a command passes the queue, then both phases, then the result register.
// a 2-entry queue sits between decode and the back end; busy is high while it is full.
// synchronous active-low reset; a per-class fill counter stands in for the reset
// chain, so no clearing pass runs. the receiver cannot stall results.
module size_class_chunk_allocator_top #(
    parameter int POOL_CHUNKS = sca_pkg::POOL_CHUNKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_kind,
    input  logic [sca_pkg::SC_W-1:0]          i_size_class,
    input  logic [sca_pkg::ADDR_W-1:0]        i_chunk_address,
    output logic                              o_result_strobe,
    output logic [sca_pkg::STATUS_W-1:0]      o_status,
    output logic [sca_pkg::ADDR_W-1:0]        o_result_address,
    output logic [sca_pkg::CLASS_W-1:0]       o_result_class,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sca_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int NC = sca_pkg::NUM_CLASSES;
    localparam int AW = $clog2(POOL_CHUNKS);
    localparam int QW = $bits(sca_pkg::t_cmd) + NC * AW;

    logic [NC-1:0][sca_pkg::ADDR_W-1:0] r_base;

    sca_pkg::t_cmd         front_cmd, q_cmd;
    logic [NC-1:0][AW-1:0] front_idx, q_idx;
    logic [QW-1:0]         q_in, q_out;
    logic                  q_full, q_empty, q_push, q_pop;
    logic                  back_idle;

    // base registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[0] <= sca_pkg::BASE_RESET0;
            r_base[1] <= sca_pkg::BASE_RESET1;
            r_base[2] <= sca_pkg::BASE_RESET2;
            r_base[3] <= sca_pkg::BASE_RESET3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sca_pkg::REG_BASE_CLASS0: r_base[0] <= i_cfg_data;
                sca_pkg::REG_BASE_CLASS1: r_base[1] <= i_cfg_data;
                sca_pkg::REG_BASE_CLASS2: r_base[2] <= i_cfg_data;
                sca_pkg::REG_BASE_CLASS3: r_base[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // decode and classify
    sca_front #(
        .POOL_CHUNKS (POOL_CHUNKS)
    ) u_front (
        .i_kind       (i_kind),
        .i_size_class (i_size_class),
        .i_addr       (i_chunk_address),
        .i_base       (r_base),
        .o_cmd        (front_cmd),
        .o_idx        (front_idx)
    );

    // command queue
    assign q_push = start && !busy;
    assign q_in   = {front_cmd, front_idx};
    assign {q_cmd, q_idx} = q_out;

    sca_fifo #(
        .WIDTH (QW),
        .DEPTH (sca_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign busy = q_full;

    // free list engine
    sca_back #(
        .POOL_CHUNKS (POOL_CHUNKS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!q_empty),
        .i_cmd     (q_cmd),
        .i_idx     (q_idx),
        .i_base    (r_base),
        .o_pop     (q_pop),
        .o_idle    (back_idle),
        .o_strobe  (o_result_strobe),
        .o_status  (o_status),
        .o_address (o_result_address),
        .o_class   (o_result_class)
    );

    // result strobes never come back to back
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobes in consecutive cycles");

    // a transaction into an idle block with an empty queue yields a result strobe after both back-end phases
    a_idle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && q_empty && back_idle) |=> ##2 o_result_strobe)
        else $error("missing result after idle transaction");

    // the back end never pops an empty queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // errors never report a class
    a_bad_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status == sca_pkg::ST_BAD)) |-> (o_result_class == '0))
        else $error("error result with nonzero class");

endmodule

[rtl/sca_ram.sv]
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sca_front.sv]
module sca_front #(
    parameter int POOL_CHUNKS = sca_pkg::POOL_CHUNKS_DEF
) (
    input  logic                                                i_kind,
    input  logic [sca_pkg::SC_W-1:0]                            i_size_class,
    input  logic [sca_pkg::ADDR_W-1:0]                          i_addr,
    input  logic [sca_pkg::NUM_CLASSES-1:0][sca_pkg::ADDR_W-1:0] i_base,
    output sca_pkg::t_cmd                                       o_cmd,
    output logic [sca_pkg::NUM_CLASSES-1:0][$clog2(POOL_CHUNKS)-1:0] o_idx
);

    localparam int AW = $clog2(POOL_CHUNKS);

    logic [sca_pkg::NUM_CLASSES-1:0][sca_pkg::ADDR_W-1:0] off;
    logic [sca_pkg::NUM_CLASSES-1:0][sca_pkg::ADDR_W-1:0] hi;
    logic [sca_pkg::NUM_CLASSES-1:0][sca_pkg::ADDR_W-1:0] mask;
    logic [sca_pkg::NUM_CLASSES-1:0]                      cand;

    // per class: offset from base, range and alignment
    always_comb begin
        for (int c = 0; c < sca_pkg::NUM_CLASSES; c++) begin
            off[c]  = i_addr - i_base[c];
            hi[c]   = off[c] >> sca_pkg::chunk_shift(sca_pkg::CLASS_W'(c));
            mask[c] = (sca_pkg::ADDR_W'(1) << sca_pkg::chunk_shift(sca_pkg::CLASS_W'(c)))
                      - sca_pkg::ADDR_W'(1);
            cand[c] = ((off[c] & mask[c]) == '0)
                      && (hi[c] < sca_pkg::ADDR_W'(POOL_CHUNKS));
            o_idx[c] = hi[c][AW-1:0];
        end
    end

    // classified command
    always_comb begin
        o_cmd.kind       = i_kind;
        o_cmd.size_class = i_size_class;
        o_cmd.addr       = i_addr;
        o_cmd.class_ok   = i_size_class < sca_pkg::SC_W'(sca_pkg::NUM_CLASSES);
        o_cmd.cand       = cand;
    end

endmodule

[rtl/sca_fifo.sv]
module sca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sca_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

[rtl/sca_back.sv]
module sca_back #(
    parameter int POOL_CHUNKS = sca_pkg::POOL_CHUNKS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    input  sca_pkg::t_cmd                                       i_cmd,
    input  logic [sca_pkg::NUM_CLASSES-1:0][$clog2(POOL_CHUNKS)-1:0] i_idx,
    input  logic [sca_pkg::NUM_CLASSES-1:0][sca_pkg::ADDR_W-1:0] i_base,
    output logic                                                o_pop,
    output logic                                                o_idle,
    output logic                                                o_strobe,
    output logic [sca_pkg::STATUS_W-1:0]                        o_status,
    output logic [sca_pkg::ADDR_W-1:0]                          o_address,
    output logic [sca_pkg::CLASS_W-1:0]                         o_class
);

    localparam int NC = sca_pkg::NUM_CLASSES;
    localparam int AW = $clog2(POOL_CHUNKS);
    localparam int IW = $clog2(POOL_CHUNKS + 1);
    localparam int EW = IW + 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_CHUNKS);

    localparam logic PH_READ    = 1'b0;
    localparam logic PH_RESOLVE = 1'b1;

    logic                  r_phase;
    sca_pkg::t_cmd         r_cmd;
    logic [NC-1:0][AW-1:0] r_idx;
    logic [NC-1:0][IW-1:0] r_head, n_head;
    logic [NC-1:0][IW-1:0] r_fresh, n_fresh;

    logic                           r_strobe;
    logic [sca_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [sca_pkg::ADDR_W-1:0]     r_address, n_address;
    logic [sca_pkg::CLASS_W-1:0]    r_class, n_class;

    sca_pkg::t_cmd         cmd_sel;
    logic [NC-1:0][AW-1:0] idx_sel;
    logic [NC-1:0][AW-1:0] ram_addr;
    logic [NC-1:0][EW-1:0] ram_rdata;
    logic [NC-1:0]         ram_we;
    logic [EW-1:0]         ram_wdata;

    logic [sca_pkg::CLASS_W-1:0] cls;
    logic [IW-1:0]               head;
    logic [IW-1:0]               link_next;
    logic                        empty;
    logic [NC-1:0]               hit;
    logic                        hit_any;
    logic [sca_pkg::CLASS_W-1:0] hit_cls;

    // ram addresses: queue head while reading, held command while updating
    always_comb begin
        cmd_sel = (r_phase == PH_READ) ? i_cmd : r_cmd;
        idx_sel = (r_phase == PH_READ) ? i_idx : r_idx;
        for (int c = 0; c < NC; c++) begin
            ram_addr[c] = (cmd_sel.kind == sca_pkg::KIND_ALLOC) ? r_head[c][AW-1:0]
                                                                : idx_sel[c];
        end
    end

    // one link and in-use ram per class
    for (genvar g = 0; g < NC; g++) begin : g_pool
        sca_ram #(
            .WIDTH (EW),
            .DEPTH (POOL_CHUNKS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_addr[g]),
            .i_wdata (ram_wdata),
            .i_raddr (ram_addr[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    // allocate: pop head, untouched chunks still chain in ascending order
    always_comb begin
        cls       = r_cmd.size_class[sca_pkg::CLASS_W-1:0];
        head      = r_head[cls];
        empty     = (head == NIL);
        link_next = (head < r_fresh[cls]) ? ram_rdata[cls][IW-1:0] : head + 1'b1;
    end

    // free: first class with a matching in-use chunk
    always_comb begin
        hit_any = 1'b0;
        hit_cls = '0;
        for (int c = 0; c < NC; c++) begin
            hit[c] = r_cmd.cand[c] && (IW'(r_idx[c]) < r_fresh[c]) && ram_rdata[c][IW];
        end
        for (int c = NC - 1; c >= 0; c--) begin
            if (hit[c]) begin
                hit_any = 1'b1;
                hit_cls = sca_pkg::CLASS_W'(c);
            end
        end
    end

    // list update and result
    always_comb begin
        n_head    = r_head;
        n_fresh   = r_fresh;
        ram_we    = '0;
        ram_wdata = '0;
        n_status  = sca_pkg::ST_BAD;
        n_address = '0;
        n_class   = '0;
        if (r_cmd.kind == sca_pkg::KIND_ALLOC) begin
            if (!r_cmd.class_ok) begin
                n_status = sca_pkg::ST_BAD;
            end else if (empty) begin
                n_status = sca_pkg::ST_EMPTY;
                n_class  = cls;
            end else begin
                n_status  = sca_pkg::ST_OK;
                n_class   = cls;
                n_address = i_base[cls]
                            + (sca_pkg::ADDR_W'(head) << sca_pkg::chunk_shift(cls));
                n_head[cls] = link_next;
                if (head == r_fresh[cls]) begin
                    n_fresh[cls] = r_fresh[cls] + 1'b1;
                end
                ram_we[cls] = (r_phase == PH_RESOLVE);
                ram_wdata   = {1'b1, head};
            end
        end else begin
            n_address = r_cmd.addr;
            if (hit_any) begin
                n_status        = sca_pkg::ST_OK;
                n_class         = hit_cls;
                n_head[hit_cls] = IW'(r_idx[hit_cls]);
                ram_we[hit_cls] = (r_phase == PH_RESOLVE);
                ram_wdata       = {1'b0, r_head[hit_cls]};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_READ;
            r_strobe <= 1'b0;
            r_head   <= '0;
            r_fresh  <= '0;
        end else begin
            r_strobe <= (r_phase == PH_RESOLVE);
            unique case (r_phase)
                PH_READ: begin
                    if (i_valid) begin
                        r_phase <= PH_RESOLVE;
                    end
                end
                PH_RESOLVE: begin
                    r_head  <= n_head;
                    r_fresh <= n_fresh;
                    r_phase <= PH_READ;
                end
                default: begin
                    r_phase <= PH_READ;
                end
            endcase
        end
    end

    // held command and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_idx <= i_idx;
        end
        if (r_phase == PH_RESOLVE) begin
            r_status  <= n_status;
            r_address <= n_address;
            r_class   <= n_class;
        end
    end

    assign o_pop     = (r_phase == PH_READ) && i_valid;
    assign o_idle    = (r_phase == PH_READ);
    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_address = r_address;
    assign o_class   = r_class;

endmodule
